[rtl/core/fwsc_pkg.sv]
`timescale 1ns / 1ps

package fwsc_pkg;

    localparam int unsigned POS_W = 15;
    localparam int unsigned LEN_W = POS_W + 1;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    localparam logic [7:0] KEY_MULT = 8'hFB;

    typedef logic [3:0][7:0] key_vec_t;

    // Entry 0 is the key byte used on the first byte of an image.
    localparam key_vec_t KEY_RESET = {8'h79, 8'h4E, 8'h75, 8'h42};

    typedef enum logic [2:0] {
        REG_MODE = 3'd0,
        REG_KEY0 = 3'd1,
        REG_KEY1 = 3'd2,
        REG_KEY2 = 3'd3,
        REG_KEY3 = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_image;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_final;
        logic       looks_encrypted;
        logic [2:0] board_code;
        logic [3:0] version_major;
        logic [3:0] version_minor;
        logic [7:0] version_build;
        logic       size_ok;
    } result_t;

    typedef struct packed {
        logic       advance;
        logic       reload;
        logic       poke;
        logic [1:0] poke_idx;
        logic [7:0] poke_data;
    } ring_ctl_t;

    function automatic logic board_nibble_ok(input logic [3:0] nib);
        return nib inside {[4'd1:4'd7]};
    endfunction

endpackage

[rtl/core/firmware_stream_cipher_with_header_probe.sv]
`timescale 1ns / 1ps
// Channel   Signals                             Moves
// item      item_valid, item_stall, item        one image byte per request
// result    result_valid, result_stall, result  one result per request
// config    cfg_we, cfg_index, cfg_data         register write, no wait
//
// One byte is accepted per cycle unless item_stall is high; its result is registered.
// The key update is one 8x8 constant multiply and two adds, done at acceptance.
// A two-entry output buffer (result register plus skid) keeps input and output apart;
// item_stall rises only when both entries are full.
// Reset loads the key registers with their defaults and clears position and captures.

module firmware_stream_cipher_with_header_probe
    import fwsc_pkg::*;
#(
    parameter int unsigned HEADER_OFFSET   = 256,
    parameter int unsigned MIN_IMAGE_BYTES = 264,
    parameter int unsigned MAX_IMAGE_BYTES = 16384
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  item_t      item,
    output logic       result_valid,
    input  logic       result_stall,
    output result_t    result,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);

    localparam logic [POS_W-1:0] HDR_POS  = POS_W'(HEADER_OFFSET);
    localparam logic [POS_W-1:0] HDR_POS1 = POS_W'(HEADER_OFFSET + 1);
    localparam logic [LEN_W-1:0] HDR_LEN  = LEN_W'(HEADER_OFFSET);
    localparam logic [LEN_W-1:0] MIN_LEN  = LEN_W'(MIN_IMAGE_BYTES);
    localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_IMAGE_BYTES);

    logic             mode_reg;
    logic             mode_next;
    key_vec_t         key_init_reg;
    key_vec_t         key_init_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [7:0]       raw_hdr_reg;
    logic [7:0]       raw_hdr_next;
    logic [7:0]       raw_hdr1_reg;
    logic [7:0]       raw_hdr1_next;
    logic [7:0]       dec_hdr_reg;
    logic [7:0]       dec_hdr_next;
    logic [7:0]       dec_hdr1_reg;
    logic [7:0]       dec_hdr1_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    result_t          out_reg;
    result_t          out_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    result_t          skid_reg;
    result_t          skid_next;

    logic             accept;
    logic             is_key_write;
    logic [1:0]       key_off;
    ring_ctl_t        ring_ctl;
    logic [7:0]       cipher_key;
    logic [7:0]       probe_key;
    logic [7:0]       out_byte;
    logic [7:0]       probe_byte;
    logic [7:0]       cipher_feed;
    logic [LEN_W-1:0] len;
    logic [7:0]       raw_hb;
    logic [7:0]       raw_hn;
    logic [7:0]       dec_hb;
    logic [7:0]       dec_hn;
    logic             enc;
    logic [7:0]       hb;
    logic [7:0]       hn;
    result_t          res_new;

    assign item_stall   = skid_valid_reg;
    assign accept       = item_valid && !skid_valid_reg;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Configuration decode.
    always_comb
    begin
        mode_next     = mode_reg;
        key_init_next = key_init_reg;
        is_key_write  = 1'b0;
        key_off       = cfg_index[1:0] - 2'(REG_KEY0);
        if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_MODE:
                begin
                    mode_next = cfg_data[0];
                end
                REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3:
                begin
                    is_key_write           = 1'b1;
                    key_init_next[key_off] = cfg_data;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        ring_ctl.advance   = accept;
        ring_ctl.reload    = accept && item.end_of_image;
        // Before the first byte of an image a key write also lands in the live ring.
        ring_ctl.poke      = is_key_write && (pos_reg == '0);
        ring_ctl.poke_idx  = key_off;
        ring_ctl.poke_data = cfg_data;
    end

    assign out_byte    = item.data_byte ^ cipher_key;
    assign probe_byte  = item.data_byte ^ probe_key;
    assign cipher_feed = mode_reg ? out_byte : item.data_byte;

    fwsc_key_ring u_cipher_ring (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ring_ctl),
        .init        (key_init_reg),
        .cipher_byte (cipher_feed),
        .key_now     (cipher_key)
    );

    fwsc_key_ring u_probe_ring (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ring_ctl),
        .init        (key_init_reg),
        .cipher_byte (item.data_byte),
        .key_now     (probe_key)
    );

    // Header captures as they stand after this byte, so a final byte at the
    // header position already sees itself.
    assign raw_hb = (pos_reg == HDR_POS)  ? item.data_byte : raw_hdr_reg;
    assign dec_hb = (pos_reg == HDR_POS)  ? probe_byte     : dec_hdr_reg;
    assign raw_hn = (pos_reg == HDR_POS1) ? item.data_byte : raw_hdr1_reg;
    assign dec_hn = (pos_reg == HDR_POS1) ? probe_byte     : dec_hdr1_reg;

    assign len = LEN_W'(pos_reg) + LEN_W'(1);
    assign enc = (len > HDR_LEN) && !board_nibble_ok(raw_hb[7:4])
                 && board_nibble_ok(dec_hb[7:4]);
    assign hb  = enc ? dec_hb : raw_hb;
    assign hn  = enc ? dec_hn : raw_hn;

    always_comb
    begin
        res_new          = '0;
        res_new.out_byte = out_byte;
        res_new.is_final = item.end_of_image;
        if (item.end_of_image)
        begin
            res_new.looks_encrypted = enc;
            res_new.board_code      = board_nibble_ok(hb[7:4]) ? hb[6:4] : 3'd0;
            res_new.version_major   = hb[7:4];
            res_new.version_minor   = hb[3:0];
            res_new.version_build   = hn;
            res_new.size_ok         = (len >= MIN_LEN) && (len <= MAX_LEN);
        end
    end

    always_comb
    begin
        pos_next      = pos_reg;
        raw_hdr_next  = raw_hdr_reg;
        raw_hdr1_next = raw_hdr1_reg;
        dec_hdr_next  = dec_hdr_reg;
        dec_hdr1_next = dec_hdr1_reg;
        if (accept)
        begin
            if (item.end_of_image)
            begin
                pos_next      = '0;
                raw_hdr_next  = '0;
                raw_hdr1_next = '0;
                dec_hdr_next  = '0;
                dec_hdr1_next = '0;
            end
            else
            begin
                pos_next      = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POS_W'(1);
                raw_hdr_next  = raw_hb;
                raw_hdr1_next = raw_hn;
                dec_hdr_next  = dec_hb;
                dec_hdr1_next = dec_hn;
            end
        end
    end

    // Output register with a skid entry behind it.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || !result_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = accept;
                out_next       = res_new;
            end
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
            skid_next       = res_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= 1'b0;
            key_init_reg   <= KEY_RESET;
            pos_reg        <= '0;
            raw_hdr_reg    <= '0;
            raw_hdr1_reg   <= '0;
            dec_hdr_reg    <= '0;
            dec_hdr1_reg   <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            key_init_reg   <= key_init_next;
            pos_reg        <= pos_next;
            raw_hdr_reg    <= raw_hdr_next;
            raw_hdr1_reg   <= raw_hdr1_next;
            dec_hdr_reg    <= dec_hdr_next;
            dec_hdr1_reg   <= dec_hdr1_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

[rtl/core/fwsc_key_ring.sv]
`timescale 1ns / 1ps

module fwsc_key_ring
    import fwsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ring_ctl_t  ctl,
    input  key_vec_t   init,
    input  logic [7:0] cipher_byte,
    output logic [7:0] key_now
);

    key_vec_t    keys_reg;
    key_vec_t    keys_next;
    logic [15:0] prod;

    assign prod    = 16'(cipher_byte) * 16'(KEY_MULT);
    assign key_now = keys_reg[0];

    always_comb
    begin
        keys_next = keys_reg;
        if (ctl.reload)
        begin
            keys_next = init;
        end
        else if (ctl.advance)
        begin
            // Fold the product into the next two keys, then rotate the ring by one.
            keys_next[0] = keys_reg[1] + prod[7:0];
            keys_next[1] = keys_reg[2] + prod[15:8];
            keys_next[2] = keys_reg[3];
            keys_next[3] = keys_reg[0];
        end
        if (ctl.poke)
        begin
            keys_next[ctl.poke_idx] = ctl.poke_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keys_reg <= KEY_RESET;
        end
        else
        begin
            keys_reg <= keys_next;
        end
    end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top
    import fwsc_pkg::*;
();

    localparam int unsigned HDR_OFFSET   = 256;
    localparam int unsigned MIN_LEN      = 264;
    localparam int unsigned MAX_LEN      = 16384;
    localparam int unsigned RANDOM_ITEMS = 350;
    // Register indexes at and above this count are not decoded by the block.
    localparam int unsigned REG_COUNT    = 5;

    typedef enum int unsigned {
        CRAFT_NONE,
        CRAFT_ENC,
        CRAFT_PLAIN
    } header_craft_t;

    class cipher_scoreboard;
        logic             mode_enc;
        key_vec_t         key_init;
        key_vec_t         cipher_ring;
        key_vec_t         probe_ring;
        logic [POS_W-1:0] position;
        logic [7:0]       raw_hdr;
        logic [7:0]       raw_hdr_next;
        logic [7:0]       dec_hdr;
        logic [7:0]       dec_hdr_next;
        result_t          expected_q[$];
        int unsigned      error_count;

        function new();
            mode_enc = 1'b0;
            key_init = KEY_RESET;
            error_count = 0;
            restart_image();
        endfunction

        function void restart_image();
            cipher_ring = key_init;
            probe_ring = key_init;
            position = '0;
            raw_hdr = 8'h00;
            raw_hdr_next = 8'h00;
            dec_hdr = 8'h00;
            dec_hdr_next = 8'h00;
        endfunction

        function logic nibble_is_board(logic [3:0] nib);
            return (nib >= 4'd1) && (nib <= 4'd7);
        endfunction

        // Fold one ciphertext byte into the ring and rotate to the next key.
        function key_vec_t roll_keys(key_vec_t ring, logic [7:0] c);
            logic [15:0] prod;
            key_vec_t    nxt;
            prod = 16'(c) * 16'(KEY_MULT);
            nxt[0] = ring[1] + prod[7:0];
            nxt[1] = ring[2] + prod[15:8];
            nxt[2] = ring[3];
            nxt[3] = ring[0];
            return nxt;
        endfunction

        function void note_config(logic [2:0] idx, logic [7:0] data);
            int k;
            case (idx)
                REG_MODE:
                    mode_enc = data[0];
                REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3:
                begin
                    k = int'(idx) - int'(REG_KEY0);
                    key_init[k] = data;
                    // At the very start of an image the live keys follow at once.
                    if (position == '0)
                    begin
                        cipher_ring[k] = data;
                        probe_ring[k] = data;
                    end
                end
                default:
                    ;
            endcase
        endfunction

        function void note_item(item_t it);
            result_t     exp;
            logic [7:0]  d;
            logic [7:0]  o;
            logic [7:0]  pd;
            logic [15:0] len;
            logic        enc;
            logic [7:0]  hb;
            logic [7:0]  hn;
            d = it.data_byte;
            o = d ^ cipher_ring[0];
            pd = d ^ probe_ring[0];
            cipher_ring = roll_keys(cipher_ring, mode_enc ? o : d);
            probe_ring = roll_keys(probe_ring, d);
            if (position == HDR_OFFSET)
            begin
                raw_hdr = d;
                dec_hdr = pd;
            end
            else if (position == HDR_OFFSET + 1)
            begin
                raw_hdr_next = d;
                dec_hdr_next = pd;
            end
            len = 16'(position) + 16'd1;
            if (position != POS_MAX)
                position = position + 1'b1;

            exp = '0;
            exp.out_byte = o;
            exp.is_final = it.end_of_image;
            if (it.end_of_image)
            begin
                enc = (len > HDR_OFFSET) && !nibble_is_board(raw_hdr[7:4])
                      && nibble_is_board(dec_hdr[7:4]);
                hb = enc ? dec_hdr : raw_hdr;
                hn = enc ? dec_hdr_next : raw_hdr_next;
                exp.looks_encrypted = enc;
                exp.board_code = nibble_is_board(hb[7:4]) ? hb[6:4] : 3'd0;
                exp.version_major = hb[7:4];
                exp.version_minor = hb[3:0];
                exp.version_build = hn;
                exp.size_ok = (len >= MIN_LEN) && (len <= MAX_LEN);
                restart_image();
            end
            expected_q.insert(expected_q.size(), exp);
        endfunction

        function void compare(string name, logic [7:0] want, logic [7:0] seen);
            if (seen !== want)
            begin
                $error("%s mismatch: expected %0h, actual %0h", name, want, seen);
                error_count++;
            end
        endfunction

        function void check_result(result_t got);
            result_t exp;
            if (expected_q.size() == 0)
            begin
                $error("result with no request pending: out_byte %0h", got.out_byte);
                error_count++;
                return;
            end
            exp = expected_q.pop_front();
            compare("out_byte", exp.out_byte, got.out_byte);
            compare("is_final", exp.is_final, got.is_final);
            compare("looks_encrypted", exp.looks_encrypted, got.looks_encrypted);
            compare("board_code", exp.board_code, got.board_code);
            compare("version_major", exp.version_major, got.version_major);
            compare("version_minor", exp.version_minor, got.version_minor);
            compare("version_build", exp.version_build, got.version_build);
            compare("size_ok", exp.size_ok, got.size_ok);
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       item_valid = 1'b0;
    logic       item_stall;
    item_t      item = '0;
    logic       result_valid;
    logic       result_stall = 1'b0;
    result_t    result;
    logic       cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    cipher_scoreboard sb = new();

    int unsigned   burst_left = 0;
    int unsigned   img_left = 0;
    header_craft_t img_craft = CRAFT_NONE;
    int unsigned   stall_left = 0;
    int unsigned   stall_style = 0;
    int unsigned   stall_cycle = 0;

    firmware_stream_cipher_with_header_probe uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    // Sender: bursts of requests with random gaps. Valid stays high across
    // back-to-back requests; callers lower it when the stream pauses.
    task automatic send_item(input logic [7:0] d, input logic eoi);
        item_t       it;
        int unsigned gap;
        it.data_byte = d;
        it.end_of_image = eoi;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_valid <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (item_stall);
        sb.note_item(it);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        sb.note_config(idx, data);
    endtask

    task automatic quiesce();
        item_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_value();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] make_byte();
        logic [7:0] b;
        logic [3:0] p;
        logic [3:0] d;
        b = pick_value();
        if (sb.position == HDR_OFFSET && img_craft == CRAFT_ENC)
        begin
            // Choose a decrypted board nibble; its raw form is not a board nibble unless the key nibble is 0.
            p = sb.probe_ring[0][7:4];
            d = (p >= 4'd1 && p <= 4'd7) ? p : 4'($urandom_range(1, 7));
            b = sb.probe_ring[0] ^ {d, 4'($urandom)};
        end
        else if (sb.position == HDR_OFFSET && img_craft == CRAFT_PLAIN)
            b = {4'($urandom_range(1, 7)), 4'($urandom)};
        return b;
    endfunction

    // Sends count bytes of the running image stream, starting new images as needed.
    task automatic send_stream(input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
        begin
            if (img_left == 0)
            begin
                case ($urandom_range(0, 3))
                    0: img_left = $urandom_range(250, 272);
                    1: img_left = $urandom_range(1, 4);
                    default: img_left = $urandom_range(1, 40);
                endcase
                img_craft = header_craft_t'($urandom_range(0, 2));
            end
            send_item(make_byte(), img_left == 1);
            img_left--;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);
    end

    // Receiver stall pattern: free running, light, heavy and periodic spells.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_style = $urandom_range(0, 3);
            stall_left = $urandom_range(50, 300);
        end
        stall_left--;
        stall_cycle++;
        case (stall_style)
            0: result_stall <= 1'b0;
            1: result_stall <= ($urandom_range(0, 3) == 0);
            2: result_stall <= ($urandom_range(0, 3) != 0);
            default: result_stall <= ((stall_cycle % 5) < 2);
        endcase
    end

    initial
    begin
        int unsigned long_len[2] = '{263, 264};
        int unsigned n;
        int unsigned rand_sent;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset keys, decrypt mode.
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b1);
        send_item(8'h5A, 1'b1);
        quiesce();

        // All-zero keys written at image start load the live keys too.
        write_reg(REG_MODE, 8'h01);
        for (int k = 0; k < 4; k++)
            write_reg(3'(int'(REG_KEY0) + k), 8'h00);
        write_reg(3'(REG_COUNT), 8'hFF);
        write_reg(3'(REG_COUNT + 2), 8'hFF);
        cfg_we <= 1'b0;
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b1);
        quiesce();

        write_reg(REG_MODE, 8'hFE);
        for (int k = 0; k < 4; k++)
            write_reg(3'(int'(REG_KEY0) + k), 8'hFF);
        cfg_we <= 1'b0;
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'h01, 1'b1);
        quiesce();

        // Mode flips in the middle of an image; the keys carry on.
        send_item(8'h12, 1'b0);
        send_item(8'hED, 1'b0);
        send_item(8'h7F, 1'b0);
        quiesce();
        write_reg(REG_MODE, 8'h01);
        cfg_we <= 1'b0;
        send_item(8'h80, 1'b0);
        send_item(8'h33, 1'b0);
        send_item(8'hCC, 1'b1);
        quiesce();

        // Key writes mid-image only apply from the next image on.
        send_item(8'hA5, 1'b0);
        send_item(8'h5A, 1'b0);
        quiesce();
        write_reg(REG_KEY0, 8'h3C);
        write_reg(REG_KEY2, 8'hC3);
        cfg_we <= 1'b0;
        send_item(8'h0F, 1'b0);
        send_item(8'hF0, 1'b1);
        send_item(8'h69, 1'b1);
        quiesce();

        // Header capture and the minimum length boundary.
        foreach (long_len[i])
        begin
            for (int r = 0; r <= REG_COUNT; r++)
                if ($urandom_range(0, 1) == 1)
                    write_reg(3'(r), pick_value());
            cfg_we <= 1'b0;
            img_left = long_len[i];
            img_craft = header_craft_t'(i % 3 + 1);
            send_stream(long_len[i]);
            quiesce();
        end

        rand_sent = 0;
        while (rand_sent < RANDOM_ITEMS)
        begin
            for (int r = 0; r <= REG_COUNT; r++)
                if ($urandom_range(0, 1) == 1)
                    write_reg(3'(r), pick_value());
            cfg_we <= 1'b0;
            n = $urandom_range(20, 150);
            send_stream(n);
            rand_sent += n;
            quiesce();
        end

        repeat (12) @(posedge clk);
        if (sb.error_count == 0 && sb.pending() == 0)
            $display("firmware_stream_cipher_with_header_probe regression: pass");
        else
            $display("firmware_stream_cipher_with_header_probe regression: fail");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("firmware_stream_cipher_with_header_probe regression: fail");
        $finish;
    end

endmodule
